// ----- rtl/core/walu_pkg.sv -----
// ----------------------------------------------------------------------------
// walu_pkg: shared types and codes of the word alu
// operation codes, sequencer states and flag bit positions
// ----------------------------------------------------------------------------
package walu_pkg;

   typedef enum logic [5:0] {
      OP_ADD = 6'd0, OP_ADDB = 6'd1, OP_SUB = 6'd2, OP_SUBB = 6'd3,
      OP_CMP = 6'd4, OP_CMPB = 6'd5, OP_OR = 6'd6, OP_ORB = 6'd7,
      OP_ANDNOT = 6'd8, OP_ANDNOTB = 6'd9, OP_MOV = 6'd10, OP_MOVB = 6'd11,
      OP_INV = 6'd12, OP_NEG = 6'd13, OP_ABS = 6'd14, OP_SWPB = 6'd15,
      OP_INC = 6'd16, OP_INCT = 6'd17, OP_DEC = 6'd18, OP_DECT = 6'd19,
      OP_CLR = 6'd20, OP_SETO = 6'd21, OP_SLA = 6'd22, OP_SRA = 6'd23,
      OP_SRC = 6'd24, OP_SRL = 6'd25, OP_COC = 6'd26, OP_CZC = 6'd27,
      OP_XOR = 6'd28, OP_MPY = 6'd29, OP_DIV = 6'd30, OP_JUMP = 6'd31,
      OP_AND = 6'd32
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_ITER, ST_DONE
   } state_type;

   // control from sequencer to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctl_type;

   localparam int unsigned FLAG_LGT = 0;
   localparam int unsigned FLAG_AGT = 1;
   localparam int unsigned FLAG_EQ  = 2;
   localparam int unsigned FLAG_C   = 3;
   localparam int unsigned FLAG_OV  = 4;
   localparam int unsigned FLAG_OP  = 5;

   // iterative ops use the shared step unit
   function automatic logic is_iter(input logic [5:0] op);
      logic r;
      r = (op == OP_SLA) || (op == OP_SRA) || (op == OP_SRC) || (op == OP_SRL)
          || (op == OP_MPY) || (op == OP_DIV);
      return r;
   endfunction

endpackage

// ----- rtl/core/walu_seq.sv -----
// ----------------------------------------------------------------------------
// walu_seq: sequencer of the word alu
// counts the steps of the shared shift / add unit and runs the handshake
// ----------------------------------------------------------------------------
module walu_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [5:0]           req_op,
   input  logic [3:0]           req_shift_count,
   input  logic                 rsp_stall,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output walu_pkg::ctl_type    ctl
);

   walu_pkg::state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       acc;

   assign acc = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         walu_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (walu_pkg::is_iter(req_op)) begin
                  state_in = walu_pkg::ST_ITER;
                  // shifts run count steps (zero means sixteen), mpy/div sixteen
                  if (req_op == walu_pkg::OP_MPY || req_op == walu_pkg::OP_DIV)
                     cnt_in = 4'd15;
                  else
                     cnt_in = req_shift_count - 4'd1;
               end else begin
                  state_in = walu_pkg::ST_DONE;
               end
            end
         end
         walu_pkg::ST_ITER: begin
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) state_in = walu_pkg::ST_DONE;
         end
         walu_pkg::ST_DONE: begin
            if (!rsp_stall) state_in = walu_pkg::ST_IDLE;
         end
         default: state_in = walu_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = (state_ff != walu_pkg::ST_IDLE);
      rsp_valid  = (state_ff == walu_pkg::ST_DONE);
      ctl.load   = acc;
      ctl.step   = (state_ff == walu_pkg::ST_ITER);
      ctl.finish = (state_ff == walu_pkg::ST_ITER) && (cnt_ff == 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= walu_pkg::ST_IDLE;
         cnt_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != walu_pkg::ST_IDLE) |-> req_stall)
      else $error("accept while busy");
   a_iter_to_done: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> rsp_valid)
      else $error("iteration did not finish");
   a_done_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped");
`endif

endmodule

// ----- rtl/core/walu_dp.sv -----
// ----------------------------------------------------------------------------
// walu_dp: datapath of the word alu
// non-iterative ops, shared shift/add-subtract step unit, status flags
// ----------------------------------------------------------------------------
module walu_dp (
   input  logic               clock,
   input  logic               reset,
   input  walu_pkg::ctl_type  ctl,
   input  logic               rsp_accept,
   input  logic [5:0]         req_op,
   input  logic [15:0]        req_src_value,
   input  logic [15:0]       req_dst_value,
   input  logic [15:0]        req_dst_next_word,
   input  logic [3:0]         req_jump_cond,
   output logic [15:0]        rsp_result_word,
   output logic [15:0]        rsp_result_second,
   output logic [1:0]         rsp_write_count,
   output logic               rsp_jump_taken,
   output logic [5:0]         flags
);

   logic [5:0]  op_ff;
   logic [15:0] hi_ff, hi_in;     // shift word / product high / partial remainder
   logic [15:0] lo_ff, lo_in;     // product low / quotient
   logic [15:0] s_ff;             // multiplicand or divisor
   logic        c_ff, c_in;       // shift carry
   logic        ov_ff, ov_in;     // sla sign change
   logic [5:0]  flag_ff, flag_in;
   logic [15:0] res_ff, res_in, res2_ff, res2_in;
   logic [1:0]  wc_ff, wc_in;
   logic        jt_ff, jt_in;

   // combinational work of the non-iterative ops
   logic [15:0] s, d, s8, d8, r, r2;
   logic [16:0] sum;
   logic [8:0]  sum8;
   logic        wfl, bfl;
   logic [1:0]  wc;
   logic        jt;
   logic [5:0]  f;
   logic        l, a, e;

   always_comb begin
      s = req_src_value;
      d = req_dst_value;
      s8 = {8'd0, s[7:0]};
      d8 = {8'd0, d[7:0]};
      r = 16'd0; r2 = 16'd0; wc = 2'd0; jt = 1'b0;
      wfl = 1'b0; bfl = 1'b0;
      f = flag_ff;
      l = flag_ff[walu_pkg::FLAG_LGT];
      a = flag_ff[walu_pkg::FLAG_AGT];
      e = flag_ff[walu_pkg::FLAG_EQ];
      sum = 17'd0; sum8 = 9'd0;
      case (req_op)
         walu_pkg::OP_ADD: begin
            sum = {1'b0, d} + {1'b0, s}; r = sum[15:0]; wc = 2'd1; wfl = 1'b1;
            f[walu_pkg::FLAG_C] = sum[16];
            f[walu_pkg::FLAG_OV] = (s[15] ^ r[15]) & (d[15] ^ r[15]);
         end
         walu_pkg::OP_ADDB: begin
            sum8 = {1'b0, d8[7:0]} + {1'b0, s8[7:0]}; r = {8'd0, sum8[7:0]};
            wc = 2'd1; bfl = 1'b1;
            f[walu_pkg::FLAG_C] = sum8[8];
            f[walu_pkg::FLAG_OV] = (s8[7] ^ r[7]) & (d8[7] ^ r[7]);
         end
         walu_pkg::OP_SUB: begin
            sum = {1'b0, d} - {1'b0, s}; r = sum[15:0]; wc = 2'd1; wfl = 1'b1;
            f[walu_pkg::FLAG_C] = !sum[16];
            f[walu_pkg::FLAG_OV] = (s[15] ^ d[15]) & (r[15] ^ d[15]);
         end
         walu_pkg::OP_SUBB: begin
            sum8 = {1'b0, d8[7:0]} - {1'b0, s8[7:0]}; r = {8'd0, sum8[7:0]};
            wc = 2'd1; bfl = 1'b1;
            f[walu_pkg::FLAG_C] = !sum8[8];
            f[walu_pkg::FLAG_OV] = (s8[7] ^ d8[7]) & (r[7] ^ d8[7]);
         end
         walu_pkg::OP_CMP: begin
            f[walu_pkg::FLAG_LGT] = s > d;
            f[walu_pkg::FLAG_AGT] = $signed(s) > $signed(d);
            f[walu_pkg::FLAG_EQ]  = s == d;
         end
         walu_pkg::OP_CMPB: begin
            f[walu_pkg::FLAG_LGT] = s8[7:0] > d8[7:0];
            f[walu_pkg::FLAG_AGT] = $signed(s8[7:0]) > $signed(d8[7:0]);
            f[walu_pkg::FLAG_EQ]  = s8[7:0] == d8[7:0];
            f[walu_pkg::FLAG_OP]  = ^s8[7:0];
         end
         walu_pkg::OP_OR:      begin r = d | s; wc = 2'd1; wfl = 1'b1; end
         walu_pkg::OP_ORB:     begin r = d8 | s8; wc = 2'd1; bfl = 1'b1; end
         walu_pkg::OP_ANDNOT:  begin r = d & ~s; wc = 2'd1; wfl = 1'b1; end
         walu_pkg::OP_ANDNOTB: begin r = d8 & ~s8; wc = 2'd1; bfl = 1'b1; end
         walu_pkg::OP_MOV:     begin r = s; wc = 2'd1; wfl = 1'b1; end
         walu_pkg::OP_MOVB:    begin r = s8; wc = 2'd1; bfl = 1'b1; end
         walu_pkg::OP_INV:     begin r = ~s; wc = 2'd1; wfl = 1'b1; end
         walu_pkg::OP_NEG: begin
            r = 16'd0 - s; wc = 2'd1; wfl = 1'b1;
            f[walu_pkg::FLAG_C] = s == 16'd0;
            f[walu_pkg::FLAG_OV] = s == 16'h8000;
         end
         walu_pkg::OP_ABS: begin
            f[walu_pkg::FLAG_LGT] = s != 16'd0;
            f[walu_pkg::FLAG_AGT] = !s[15] && (s != 16'd0);
            f[walu_pkg::FLAG_EQ]  = s == 16'd0;
            f[walu_pkg::FLAG_OV]  = s == 16'h8000;
            r = s[15] ? (16'd0 - s) : s; wc = 2'd1;
         end
         walu_pkg::OP_SWPB: begin r = {s[7:0], s[15:8]}; wc = 2'd1; end
         walu_pkg::OP_INC, walu_pkg::OP_INCT: begin
            sum = {1'b0, s} + ((req_op == walu_pkg::OP_INC) ? 17'd1 : 17'd2);
            r = sum[15:0]; wc = 2'd1; wfl = 1'b1;
            f[walu_pkg::FLAG_C] = sum[16];
            f[walu_pkg::FLAG_OV] = !s[15] && r[15];
         end
         walu_pkg::OP_DEC, walu_pkg::OP_DECT: begin
            sum = {1'b0, s} - ((req_op == walu_pkg::OP_DEC) ? 17'd1 : 17'd2);
            r = sum[15:0]; wc = 2'd1; wfl = 1'b1;
            f[walu_pkg::FLAG_C] = !sum[16];
            f[walu_pkg::FLAG_OV] = s[15] && !r[15];
         end
         walu_pkg::OP_CLR:  begin r = 16'd0; wc = 2'd1; end
         walu_pkg::OP_SETO: begin r = 16'hffff; wc = 2'd1; end
         walu_pkg::OP_COC:  f[walu_pkg::FLAG_EQ] = (s & d) == s;
         walu_pkg::OP_CZC:  f[walu_pkg::FLAG_EQ] = (s & d) == 16'd0;
         walu_pkg::OP_XOR:  begin r = s ^ d; wc = 2'd1; wfl = 1'b1; end
         walu_pkg::OP_AND:  begin r = d & s; wc = 2'd1; wfl = 1'b1; end
         walu_pkg::OP_JUMP: begin
            case (req_jump_cond)
               4'd0:  jt = 1'b1;
               4'd1:  jt = !a && !e;
               4'd2:  jt = !l || e;
               4'd3:  jt = e;
               4'd4:  jt = l || e;
               4'd5:  jt = a;
               4'd6:  jt = !e;
               4'd7:  jt = !flag_ff[walu_pkg::FLAG_C];
               4'd8:  jt = flag_ff[walu_pkg::FLAG_C];
               4'd9:  jt = !flag_ff[walu_pkg::FLAG_OV];
               4'd10: jt = !l && !e;
               4'd11: jt = l && !e;
               4'd12: jt = flag_ff[walu_pkg::FLAG_OP];
               default: jt = 1'b0;
            endcase
         end
         default: ;
      endcase
      if (wfl) begin
         f[walu_pkg::FLAG_LGT] = r != 16'd0;
         f[walu_pkg::FLAG_AGT] = !r[15] && (r != 16'd0);
         f[walu_pkg::FLAG_EQ]  = r == 16'd0;
      end
      if (bfl) begin
         f[walu_pkg::FLAG_LGT] = r[7:0] != 8'd0;
         f[walu_pkg::FLAG_AGT] = !r[7] && (r[7:0] != 8'd0);
         f[walu_pkg::FLAG_EQ]  = r[7:0] == 8'd0;
         f[walu_pkg::FLAG_OP]  = ^r[7:0];
      end
   end

   // shared step unit: one shift or one add/subtract bit per cycle
   logic [16:0] add_m, sub_d;
   logic [15:0] shr;
   always_comb begin
      hi_in = hi_ff; lo_in = lo_ff; c_in = c_ff; ov_in = ov_ff;
      add_m = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, s_ff} : 17'd0);
      sub_d = {hi_ff, lo_ff[15]} - {1'b0, s_ff};
      shr = {1'b0, hi_ff[15:1]};
      case (op_ff)
         walu_pkg::OP_SLA: begin
            c_in = hi_ff[15];
            hi_in = {hi_ff[14:0], 1'b0};
            ov_in = ov_ff | (hi_ff[15] ^ hi_ff[14]);
         end
         walu_pkg::OP_SRA: begin
            c_in = hi_ff[0]; hi_in = {hi_ff[15], hi_ff[15:1]};
         end
         walu_pkg::OP_SRC: begin
            c_in = hi_ff[0]; hi_in = {hi_ff[0], hi_ff[15:1]};
         end
         walu_pkg::OP_SRL: begin
            c_in = hi_ff[0]; hi_in = shr;
         end
         walu_pkg::OP_MPY: begin
            // shift-add, product high in hi, low in lo
            hi_in = add_m[16:1];
            lo_in = {add_m[0], lo_ff[15:1]};
         end
         walu_pkg::OP_DIV: begin
            // restoring divide, partial remainder stays below divisor when the divisor exceeds the high dividend word
            if (!sub_d[16]) begin
               hi_in = sub_d[15:0];
               lo_in = {lo_ff[14:0], 1'b1};
            end else begin
               hi_in = {hi_ff[14:0], lo_ff[15]};
               lo_in = {lo_ff[14:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   // result capture and flag update
   always_comb begin
      res_in = res_ff; res2_in = res2_ff; wc_in = wc_ff; jt_in = jt_ff;
      flag_in = flag_ff;
      if (ctl.load) begin
         res_in = r; res2_in = r2; wc_in = wc; jt_in = jt;
         if (!walu_pkg::is_iter(req_op)) flag_in = f;
         else if (req_op == walu_pkg::OP_DIV && req_src_value <= req_dst_value) begin
            flag_in[walu_pkg::FLAG_OV] = 1'b1;
         end
      end else if (ctl.finish) begin
         case (op_ff)
            walu_pkg::OP_MPY: begin
               res_in = hi_in; res2_in = lo_in; wc_in = 2'd2;
            end
            walu_pkg::OP_DIV: begin
               if (s_ff > res2_ff) begin
                  res_in = lo_in; res2_in = hi_in; wc_in = 2'd2;
                  flag_in[walu_pkg::FLAG_OV] = 1'b0;
               end else begin
                  res_in = 16'd0; res2_in = 16'd0; wc_in = 2'd0;
               end
            end
            default: begin
               res_in = hi_in; wc_in = 2'd1;
               flag_in[walu_pkg::FLAG_C] = c_in;
               if (op_ff == walu_pkg::OP_SLA) flag_in[walu_pkg::FLAG_OV] = ov_in;
               flag_in[walu_pkg::FLAG_LGT] = hi_in != 16'd0;
               flag_in[walu_pkg::FLAG_AGT] = !hi_in[15] && (hi_in != 16'd0);
               flag_in[walu_pkg::FLAG_EQ]  = hi_in == 16'd0;
            end
         endcase
      end
   end

   // operand registers (res2 holds the high dividend word during divide)
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         op_ff <= req_op;
         s_ff  <= req_src_value;
         c_ff  <= flag_ff[walu_pkg::FLAG_C];
         ov_ff <= 1'b0;
         if (req_op == walu_pkg::OP_MPY) begin
            hi_ff <= 16'd0; lo_ff <= req_dst_value;
         end else if (req_op == walu_pkg::OP_DIV) begin
            hi_ff <= req_dst_value; lo_ff <= req_dst_next_word;
         end else begin
            hi_ff <= req_dst_value; lo_ff <= 16'd0;
         end
      end else if (ctl.step) begin
         hi_ff <= hi_in; lo_ff <= lo_in; c_ff <= c_in; ov_ff <= ov_in;
      end
      res_ff <= res_in;
      res2_ff <= (ctl.load && req_op == walu_pkg::OP_DIV) ? req_dst_value : res2_in;
      wc_ff <= wc_in;
      jt_ff <= jt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) flag_ff <= 6'd0;
      else       flag_ff <= flag_in;
   end

   assign rsp_result_word   = res_ff;
   assign rsp_result_second = res2_ff;
   assign rsp_write_count   = wc_ff;
   assign rsp_jump_taken    = jt_ff;
   assign flags             = flag_ff;

`ifndef SYNTHESIS
   a_div_quot_ok: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && op_ff == walu_pkg::OP_DIV && s_ff > res2_ff) |-> (hi_ff < s_ff))
      else $error("partial remainder out of range");
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      (!ctl.load && !ctl.finish) |=> $stable(flag_ff))
      else $error("flags changed while idle");
   a_wc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_accept |-> (wc_ff != 2'd3))
      else $error("bad write count");
`endif

endmodule

// ----- rtl/core/word_alu_with_status_flags.sv -----
// non-iterative ops deliver the result in the cycle after accept
// shifts step once per position shifted (1..16), multiply and divide once per word bit
// one transaction at a time: a new request is taken only while the sequencer is idle
// synchronous reset clears the status flags and the sequencer
// ----------------------------------------------------------------------------
// word_alu_with_status_flags: 16-bit execute unit with status flags
// sequencer plus datapath with a shared shift / add-subtract step unit
// ----------------------------------------------------------------------------
module word_alu_with_status_flags (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_op,
   input  logic [15:0] req_src_value,
   input  logic [15:0] req_dst_value,
   input  logic [15:0] req_dst_next_word,
   input  logic [3:0]  req_shift_count,
   input  logic [3:0]  req_jump_cond,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_word,
   output logic [15:0] rsp_result_second,
   output logic [1:0]  rsp_write_count,
   output logic        rsp_jump_taken,
   output logic        rsp_flag_logical_greater,
   output logic        rsp_flag_arith_greater,
   output logic        rsp_flag_equal,
   output logic        rsp_flag_carry,
   output logic        rsp_flag_overflow,
   output logic        rsp_flag_odd_parity
);

   walu_pkg::ctl_type ctl;
   logic [5:0] flags;

   // sequencer
   walu_seq u_seq (
      .clock, .reset, .req_valid, .req_op, .req_shift_count, .rsp_stall,
      .req_stall, .rsp_valid, .ctl
   );

   // datapath
   walu_dp u_dp (
      .clock, .reset, .ctl, .rsp_accept(rsp_valid && !rsp_stall),
      .req_op, .req_src_value, .req_dst_value, .req_dst_next_word, .req_jump_cond,
      .rsp_result_word, .rsp_result_second, .rsp_write_count, .rsp_jump_taken, .flags
   );

   assign rsp_flag_logical_greater = flags[walu_pkg::FLAG_LGT];
   assign rsp_flag_arith_greater   = flags[walu_pkg::FLAG_AGT];
   assign rsp_flag_equal           = flags[walu_pkg::FLAG_EQ];
   assign rsp_flag_carry           = flags[walu_pkg::FLAG_C];
   assign rsp_flag_overflow        = flags[walu_pkg::FLAG_OV];
   assign rsp_flag_odd_parity      = flags[walu_pkg::FLAG_OP];

endmodule
